@@ rtl/core/gastar_pkg.sv @@
// Shared types and constants for the grid A* next-step block.
`timescale 1ns / 1ps
`default_nettype none
package gastar_pkg;

   localparam int POS_W = 5;
   localparam int F_W   = 22;
   localparam int G_W   = 21;

   localparam logic [F_W-1:0] F_UNVISITED = 22'h3FFFFF;
   localparam logic [F_W-1:0] F_LIMIT     = 22'h3FFFFE;
   localparam logic [G_W-1:0] G_LIMIT     = 21'h1FFFFF;

   localparam logic [10:0] COST_STRAIGHT = 11'd1000;
   localparam logic [10:0] COST_DIAG     = 11'd1414;
   localparam logic [19:0] HEUR_SCALE    = 20'd1000000;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SEARCH = 1'b1;

   // Neighbor order N, S, E, W, NE, NW, SE, SW as two-bit signed offsets.
   localparam logic [1:0] STEP_DR [8] = '{2'b11, 2'b01, 2'b00, 2'b00,
                                          2'b11, 2'b11, 2'b01, 2'b01};
   localparam logic [1:0] STEP_DC [8] = '{2'b00, 2'b00, 2'b01, 2'b11,
                                          2'b01, 2'b11, 2'b01, 2'b11};

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_SRC_INIT,
      ST_SCAN,
      ST_SCAN_END,
      ST_EXP_G,
      ST_NB_ADDR,
      ST_NB_CHECK,
      ST_NB_SQ,
      ST_NB_SQRT,
      ST_NB_UPD,
      ST_WALK_CHK,
      ST_WALK_RD,
      ST_EMIT
   } state_type;

endpackage
`default_nettype wire

@@ rtl/core/grid_astar_next_step.sv @@
// Top level: A* search over a blocked-cell grid that returns the first step.
// Load item: no result. Search item with an in-grid source apart from the destination:
// a clear of the node memory, then per expanded cell an open-set scan over the node
// memory plus up to 8 neighbors, each via the square root unit, then the parent walk.
// N = GRID_ROWS*GRID_COLS; the scan over the node memory sets the search time.
// After reset a pass over the N cells clears the blocked map; no item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none
module grid_astar_next_step
   import gastar_pkg::*;
#(
   parameter int GRID_ROWS = 32,
   parameter int GRID_COLS = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // pos_row[4:0], pos_col[9:5], blocked[10], dest_row[15:11], dest_col[20:16]
   input  wire logic [23:0] req_tdata,
   // func[0]
   input  wire logic [0:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // next_row[4:0], next_col[9:5], path_found[10]
   output logic [15:0]      rsp_tdata
);

   localparam int NCELLS = GRID_ROWS * GRID_COLS;
   localparam int IW  = $clog2(NCELLS);
   localparam int RB  = $clog2(GRID_ROWS);
   localparam int CB  = $clog2(GRID_COLS);
   localparam int XW0 = (RB > CB) ? RB : CB;
   localparam int XW  = (XW0 > POS_W) ? XW0 : POS_W;
   localparam int SQW = 2 * XW + 1;
   localparam int PW  = SQW + 20;
   localparam int SW  = PW + (PW % 2);
   localparam int HW  = SW / 2;
   localparam int NW  = 1 + F_W;
   localparam int GPW = G_W + 2 * XW;

   function automatic logic [IW-1:0] cell_idx(input logic [XW-1:0] r, input logic [XW-1:0] c);
      cell_idx = IW'(32'(r) * 32'(GRID_COLS) + 32'(c));
   endfunction

   // Memories
   logic [0:0]     blk_mem  [0:NCELLS-1];
   logic [NW-1:0]  node_mem [0:NCELLS-1];
   logic [GPW-1:0] gp_mem   [0:NCELLS-1];

   logic           blk_we, blk_re, blk_wdata;
   logic [IW-1:0]  blk_waddr, blk_raddr;
   logic           blk_rdata_ff;
   logic           node_we, node_re;
   logic [IW-1:0]  node_waddr, node_raddr;
   logic [NW-1:0]  node_wdata, node_rdata_ff;
   logic           gp_we, gp_re;
   logic [IW-1:0]  gp_waddr, gp_raddr;
   logic [GPW-1:0] gp_wdata, gp_rdata_ff;

   state_type      state_ff, state_in;
   logic [IW:0]    cnt_ff, cnt_in;
   logic [XW-1:0]  scan_r_ff, scan_r_in, scan_c_ff, scan_c_in;
   logic [XW-1:0]  p_r_ff, p_r_in, p_c_ff, p_c_in;
   logic [XW-1:0]  best_r_ff, best_r_in, best_c_ff, best_c_in;
   logic [F_W-1:0] best_f_ff, best_f_in;
   logic           best_ok_ff, best_ok_in;
   logic [XW-1:0]  src_r_ff, src_r_in, src_c_ff, src_c_in;
   logic [XW-1:0]  dst_r_ff, dst_r_in, dst_c_ff, dst_c_in;
   logic [2:0]     k_ff, k_in;
   logic [G_W-1:0] g_best_ff, g_best_in, g_ff, g_in;
   logic [XW-1:0]  nb_r_ff, nb_r_in, nb_c_ff, nb_c_in;
   logic [F_W-1:0] nb_f_ff, nb_f_in;
   logic [SQW-1:0] sq_ff, sq_in;
   logic [XW-1:0]  step_r_ff, step_r_in, step_c_ff, step_c_in;
   logic [XW-1:0]  cur_r_ff, cur_r_in, cur_c_ff, cur_c_in;
   logic [XW-1:0]  res_r_ff, res_r_in, res_c_ff, res_c_in;
   logic           res_found_ff, res_found_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic           rsp_found_ff, rsp_found_in;

   logic           sqrt_start, sqrt_done;
   logic [HW-1:0]  sqrt_root;
   logic [SW-1:0]  sqrt_operand;

   logic [POS_W-1:0] in_row, in_col, in_drow, in_dcol;
   logic           in_blocked, in_grid, in_same;
   logic [XW:0]    nr_w, nc_w;
   logic [XW-1:0]  nr, nc;
   logic           nb_inb;
   logic [1:0]     dr, dc;
   logic [XW-1:0]  abs_r, abs_c;
   logic [G_W:0]   g_sum;
   logic [F_W:0]   f_sum;
   logic [F_W-1:0] f_new;
   logic           nb_next, scan_start;

   assign in_row     = req_tdata[4:0];
   assign in_col     = req_tdata[9:5];
   assign in_blocked = req_tdata[10];
   assign in_drow    = req_tdata[15:11];
   assign in_dcol    = req_tdata[20:16];
   assign in_grid    = (32'(in_row) < GRID_ROWS) && (32'(in_col) < GRID_COLS);
   assign in_same    = (in_row == in_drow) && (in_col == in_dcol);

   // Neighbor coordinates; a step below zero wraps high and fails the bound check.
   always_comb begin
      dr     = STEP_DR[k_ff];
      dc     = STEP_DC[k_ff];
      nr_w   = {1'b0, best_r_ff} + {{(XW-1){dr[1]}}, dr};
      nc_w   = {1'b0, best_c_ff} + {{(XW-1){dc[1]}}, dc};
      nr     = nr_w[XW-1:0];
      nc     = nc_w[XW-1:0];
      nb_inb = (32'(nr_w) < GRID_ROWS) && (32'(nc_w) < GRID_COLS);
      abs_r  = (nb_r_ff > dst_r_ff) ? nb_r_ff - dst_r_ff : dst_r_ff - nb_r_ff;
      abs_c  = (nb_c_ff > dst_c_ff) ? nb_c_ff - dst_c_ff : dst_c_ff - nb_c_ff;
      g_sum  = {1'b0, g_best_ff} + (G_W+1)'(k_ff[2] ? COST_DIAG : COST_STRAIGHT);
      f_sum  = (F_W+1)'(g_ff) + (F_W+1)'(sqrt_root);
      f_new  = (f_sum > (F_W+1)'(F_LIMIT)) ? F_LIMIT : f_sum[F_W-1:0];
      sqrt_operand = SW'(sq_ff) * SW'(HEUR_SCALE);
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_r_in    = scan_r_ff;
      scan_c_in    = scan_c_ff;
      p_r_in       = p_r_ff;
      p_c_in       = p_c_ff;
      best_r_in    = best_r_ff;
      best_c_in    = best_c_ff;
      best_f_in    = best_f_ff;
      best_ok_in   = best_ok_ff;
      src_r_in     = src_r_ff;
      src_c_in     = src_c_ff;
      dst_r_in     = dst_r_ff;
      dst_c_in     = dst_c_ff;
      k_in         = k_ff;
      g_best_in    = g_best_ff;
      g_in         = g_ff;
      nb_r_in      = nb_r_ff;
      nb_c_in      = nb_c_ff;
      nb_f_in      = nb_f_ff;
      sq_in        = sq_ff;
      step_r_in    = step_r_ff;
      step_c_in    = step_c_ff;
      cur_r_in     = cur_r_ff;
      cur_c_in     = cur_c_ff;
      res_r_in     = res_r_ff;
      res_c_in     = res_c_ff;
      res_found_in = res_found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_found_in = rsp_found_ff;
      blk_we = 1'b0; blk_re = 1'b0; blk_wdata = 1'b0;
      blk_waddr = '0; blk_raddr = '0;
      node_we = 1'b0; node_re = 1'b0; node_wdata = '0;
      node_waddr = '0; node_raddr = '0;
      gp_we = 1'b0; gp_re = 1'b0; gp_wdata = '0;
      gp_waddr = '0; gp_raddr = '0;
      req_tready = 1'b0;
      sqrt_start = 1'b0;
      nb_next    = 1'b0;
      scan_start = 1'b0;

      case (state_ff)
         ST_INIT: begin
            blk_we    = 1'b1;
            blk_waddr = cnt_ff[IW-1:0];
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(NCELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               src_r_in = XW'(in_row);
               src_c_in = XW'(in_col);
               dst_r_in = XW'(in_drow);
               dst_c_in = XW'(in_dcol);
               res_r_in = XW'(in_row);
               res_c_in = XW'(in_col);
               if (req_tuser[0] == FUNC_LOAD) begin
                  if (in_grid) begin
                     blk_we    = 1'b1;
                     blk_waddr = cell_idx(XW'(in_row), XW'(in_col));
                     blk_wdata = in_blocked;
                  end
               end else if (!in_grid) begin
                  res_found_in = 1'b0;
                  state_in     = ST_EMIT;
               end else if (in_same) begin
                  res_found_in = 1'b1;
                  state_in     = ST_EMIT;
               end else begin
                  cnt_in   = '0;
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_CLEAR: begin
            node_we    = 1'b1;
            node_waddr = cnt_ff[IW-1:0];
            node_wdata = {1'b0, F_UNVISITED};
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == (IW+1)'(NCELLS - 1)) begin
               state_in = ST_SRC_INIT;
            end
         end
         ST_SRC_INIT: begin
            node_we    = 1'b1;
            node_waddr = cell_idx(src_r_ff, src_c_ff);
            node_wdata = '0;
            gp_we      = 1'b1;
            gp_waddr   = cell_idx(src_r_ff, src_c_ff);
            gp_wdata   = {{G_W{1'b0}}, src_r_ff, src_c_ff};
            scan_start = 1'b1;
         end
         ST_SCAN: begin
            // Read of entry cnt is issued while entry cnt-1 is compared.
            if (cnt_ff != '0 && !node_rdata_ff[F_W] && node_rdata_ff[F_W-1:0] < best_f_ff)
            begin
               best_f_in  = node_rdata_ff[F_W-1:0];
               best_r_in  = p_r_ff;
               best_c_in  = p_c_ff;
               best_ok_in = 1'b1;
            end
            if (cnt_ff < (IW+1)'(NCELLS)) begin
               node_re    = 1'b1;
               node_raddr = cnt_ff[IW-1:0];
               p_r_in     = scan_r_ff;
               p_c_in     = scan_c_ff;
               if (32'(scan_c_ff) == GRID_COLS - 1) begin
                  scan_c_in = '0;
                  scan_r_in = scan_r_ff + 1'b1;
               end else begin
                  scan_c_in = scan_c_ff + 1'b1;
               end
               cnt_in = cnt_ff + 1'b1;
            end else begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (!best_ok_ff) begin
               res_r_in     = src_r_ff;
               res_c_in     = src_c_ff;
               res_found_in = 1'b0;
               state_in     = ST_EMIT;
            end else begin
               node_we    = 1'b1;
               node_waddr = cell_idx(best_r_ff, best_c_ff);
               node_wdata = {1'b1, best_f_ff};
               gp_re      = 1'b1;
               gp_raddr   = cell_idx(best_r_ff, best_c_ff);
               state_in   = ST_EXP_G;
            end
         end
         ST_EXP_G: begin
            g_best_in = gp_rdata_ff[GPW-1 -: G_W];
            k_in      = '0;
            state_in  = ST_NB_ADDR;
         end
         ST_NB_ADDR: begin
            if (!nb_inb) begin
               nb_next = 1'b1;
            end else if (nr == dst_r_ff && nc == dst_c_ff) begin
               step_r_in = nr;
               step_c_in = nc;
               cur_r_in  = best_r_ff;
               cur_c_in  = best_c_ff;
               state_in  = ST_WALK_CHK;
            end else begin
               node_re    = 1'b1;
               node_raddr = cell_idx(nr, nc);
               blk_re     = 1'b1;
               blk_raddr  = cell_idx(nr, nc);
               nb_r_in    = nr;
               nb_c_in    = nc;
               state_in   = ST_NB_CHECK;
            end
         end
         ST_NB_CHECK: begin
            if (node_rdata_ff[F_W] || blk_rdata_ff) begin
               nb_next = 1'b1;
            end else begin
               g_in     = (g_sum > (G_W+1)'(G_LIMIT)) ? G_LIMIT : g_sum[G_W-1:0];
               nb_f_in  = node_rdata_ff[F_W-1:0];
               sq_in    = SQW'(abs_r) * SQW'(abs_r) + SQW'(abs_c) * SQW'(abs_c);
               state_in = ST_NB_SQ;
            end
         end
         ST_NB_SQ: begin
            sqrt_start = 1'b1;
            state_in   = ST_NB_SQRT;
         end
         ST_NB_SQRT: begin
            if (sqrt_done) begin
               state_in = ST_NB_UPD;
            end
         end
         ST_NB_UPD: begin
            if (nb_f_ff > f_new) begin
               node_we    = 1'b1;
               node_waddr = cell_idx(nb_r_ff, nb_c_ff);
               node_wdata = {1'b0, f_new};
               gp_we      = 1'b1;
               gp_waddr   = cell_idx(nb_r_ff, nb_c_ff);
               gp_wdata   = {g_ff, best_r_ff, best_c_ff};
            end
            nb_next = 1'b1;
         end
         ST_WALK_CHK: begin
            if (cur_r_ff == src_r_ff && cur_c_ff == src_c_ff) begin
               res_r_in     = step_r_ff;
               res_c_in     = step_c_ff;
               res_found_in = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               step_r_in = cur_r_ff;
               step_c_in = cur_c_ff;
               gp_re     = 1'b1;
               gp_raddr  = cell_idx(cur_r_ff, cur_c_ff);
               state_in  = ST_WALK_RD;
            end
         end
         ST_WALK_RD: begin
            cur_r_in = gp_rdata_ff[2*XW-1 -: XW];
            cur_c_in = gp_rdata_ff[XW-1:0];
            state_in = ST_WALK_CHK;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = res_r_ff[POS_W-1:0];
               rsp_col_in   = res_c_ff[POS_W-1:0];
               rsp_found_in = res_found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (nb_next) begin
         if (k_ff == 3'd7) begin
            scan_start = 1'b1;
         end else begin
            k_in     = k_ff + 1'b1;
            state_in = ST_NB_ADDR;
         end
      end
      if (scan_start) begin
         cnt_in     = '0;
         scan_r_in  = '0;
         scan_c_in  = '0;
         best_ok_in = 1'b0;
         best_f_in  = F_UNVISITED;
         state_in   = ST_SCAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_r_ff    <= scan_r_in;
      scan_c_ff    <= scan_c_in;
      p_r_ff       <= p_r_in;
      p_c_ff       <= p_c_in;
      best_r_ff    <= best_r_in;
      best_c_ff    <= best_c_in;
      best_f_ff    <= best_f_in;
      best_ok_ff   <= best_ok_in;
      src_r_ff     <= src_r_in;
      src_c_ff     <= src_c_in;
      dst_r_ff     <= dst_r_in;
      dst_c_ff     <= dst_c_in;
      k_ff         <= k_in;
      g_best_ff    <= g_best_in;
      g_ff         <= g_in;
      nb_r_ff      <= nb_r_in;
      nb_c_ff      <= nb_c_in;
      nb_f_ff      <= nb_f_in;
      sq_ff        <= sq_in;
      step_r_ff    <= step_r_in;
      step_c_ff    <= step_c_in;
      cur_r_ff     <= cur_r_in;
      cur_c_ff     <= cur_c_in;
      res_r_ff     <= res_r_in;
      res_c_ff     <= res_c_in;
      res_found_ff <= res_found_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_found_ff <= rsp_found_in;
   end

   always_ff @(posedge clock) begin
      if (blk_we) begin
         blk_mem[blk_waddr] <= blk_wdata;
      end
      if (blk_re) begin
         blk_rdata_ff <= blk_mem[blk_raddr][0];
      end
   end

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[node_waddr] <= node_wdata;
      end
      if (node_re) begin
         node_rdata_ff <= node_mem[node_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (gp_we) begin
         gp_mem[gp_waddr] <= gp_wdata;
      end
      if (gp_re) begin
         gp_rdata_ff <= gp_mem[gp_raddr];
      end
   end

   gastar_isqrt #(
      .OP_W (SW)
   ) u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .done    (sqrt_done),
      .root    (sqrt_root)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_found_ff, rsp_col_ff, rsp_row_ff};

   // A finished result never overwrites one that is still waiting.
   a_emit_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && rsp_valid_ff && !rsp_tready) |=> state_ff == ST_EMIT)
      else $error("result slot overwritten while stalled");

   // The open-set scan relies on the node memory staying untouched.
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (!node_we && !gp_we))
      else $error("node memory written during scan");

   a_search_clears: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == FUNC_SEARCH && in_grid && !in_same)
      |=> state_ff == ST_CLEAR)
      else $error("search started without clearing node memory");

   a_upd_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NB_UPD) |-> (32'(nb_r_ff) < GRID_ROWS && 32'(nb_c_ff) < GRID_COLS))
      else $error("neighbor update outside the grid");

endmodule
`default_nettype wire

@@ rtl/core/gastar_isqrt.sv @@
// Multi-cycle integer square root, two operand bits per cycle.
`timescale 1ns / 1ps
`default_nettype none
module gastar_isqrt #(
   parameter int OP_W = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [OP_W-1:0]   operand,
   output logic                   done,
   output logic [OP_W/2-1:0]      root
);

   localparam int RW = OP_W / 2;
   localparam int CNT_W = $clog2(RW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [RW+1:0]     rem_ff, rem_in;
   logic [RW-1:0]     root_ff, root_in;
   logic [RW+1:0]     rem_n;
   logic [RW+1:0]     trial;

   always_comb begin
      rem_n   = {rem_ff[RW-1:0], op_ff[OP_W-1 -: 2]};
      trial   = {root_ff, 2'b01};
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         op_in   = operand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         op_in = {op_ff[OP_W-3:0], 2'b00};
         if (rem_n >= trial) begin
            rem_in  = rem_n - trial;
            root_in = {root_ff[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_n;
            root_in = {root_ff[RW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(RW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire
